// ===== design/bracket_text_tokenizer_core_macros.svh =====
// Assertion macros for the bracket text tokenizer core.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef BRACKET_TEXT_TOKENIZER_CORE_MACROS_SVH
`define BRACKET_TEXT_TOKENIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BTT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("btt check failed");
`define BTT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("btt check failed");
`else
`define BTT_ASSERT(label, prop)
`define BTT_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== design/btt_pkg.sv =====
// Shared types, constants and helpers for the bracket text tokenizer.
// No dependencies; used by every module of the core.
package btt_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int DEPTH_BITS  = 8;
  localparam int MAX_RES     = 3;
  localparam int CNT_BITS    = 2;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [3:0] {
    K_TEXT         = 4'd0,
    K_STRING       = 4'd1,
    K_OPEN_ROUND   = 4'd2,
    K_OPEN_SQUARE  = 4'd3,
    K_OPEN_CURLY   = 4'd4,
    K_CLOSE_ROUND  = 4'd5,
    K_CLOSE_SQUARE = 4'd6,
    K_CLOSE_CURLY  = 4'd7,
    K_END_OK       = 4'd8,
    K_ERROR        = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_TEXT,
    M_STR,
    M_ESC,
    M_LINE,
    M_BLOCK
  } lex_mode_t;

  typedef enum logic [1:0] {
    H_NONE,
    H_SLASH,
    H_STAR
  } held_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] tok_begin;
    logic [31:0] tok_length;
    logic [31:0] line;
  } tok_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]  cnt;
    tok_t [MAX_RES-1:0]   toks;
  } bundle_t;

  function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic logic is_bracket(input logic [7:0] b);
    return b inside {CH_LPAREN, CH_LBRACK, CH_LBRACE, CH_RPAREN, CH_RBRACK, CH_RBRACE};
  endfunction

  function automatic kind_t bracket_kind(input logic [7:0] b);
    kind_t k;
    case (b)
      CH_LPAREN: k = K_OPEN_ROUND;
      CH_LBRACK: k = K_OPEN_SQUARE;
      CH_LBRACE: k = K_OPEN_CURLY;
      CH_RPAREN: k = K_CLOSE_ROUND;
      CH_RBRACK: k = K_CLOSE_SQUARE;
      CH_RBRACE: k = K_CLOSE_CURLY;
      default:   k = K_TEXT;
    endcase
    return k;
  endfunction

  function automatic logic ends_text(input logic [7:0] b);
    return is_bracket(b) ||
           (b inside {CH_DQUOTE, CH_SQUOTE, CH_SPACE, CH_TAB, CH_LF, CH_CR,
                      CH_BS, CH_FF, CH_NUL, CH_COMMA, CH_SEMI});
  endfunction

endpackage

// ===== design/btt_front.sv =====
// Lexer front end: per-byte mode update and token bundle generation.
// Depends on btt_pkg; feeds btt_queue with one bundle per productive byte.
module btt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       in_src_byte,
  input  logic             in_end_of_source,
  output btt_pkg::bundle_t bundle
);
  import btt_pkg::*;

  lex_mode_t              mode_r, mode_nxt;
  held_t                  held_r, held_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [31:0]            line_r, line_nxt;
  logic [DEPTH_BITS-1:0]  depth_r, depth_nxt;
  logic                   single_r, single_nxt;

  logic [7:0]             b;
  logic                   is_lf;
  logic [OFFSET_BITS-1:0] off_inc;
  logic [31:0]            line_inc;
  logic [7:0]             quote_ch;
  logic                   do_text;
  logic                   do_idle;
  logic [CNT_BITS-1:0]    n;
  tok_t [MAX_RES-1:0]     toks;

  assign b        = in_src_byte;
  assign is_lf    = (b == CH_LF);
  assign off_inc  = off_r + OFFSET_BITS'(1);
  assign line_inc = line_r + 32'(is_lf);
  assign quote_ch = single_r ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    start_nxt  = start_r;
    depth_nxt  = depth_r;
    single_nxt = single_r;
    off_nxt    = off_inc;
    line_nxt   = line_inc;
    toks       = '0;
    n          = '0;
    do_text    = 1'b0;
    do_idle    = 1'b0;

    case (mode_r)
      M_TEXT: begin
        do_text = 1'b1;
      end
      M_STR: begin
        if (b == quote_ch) begin
          toks[n] = '{kind: K_STRING, tok_begin: to32(start_r),
                      tok_length: to32(off_r - start_r), line: line_r};
          n = n + CNT_BITS'(1);
          mode_nxt = M_IDLE;
        end else if (b == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end
      end
      M_ESC: begin
        mode_nxt = M_STR;
      end
      M_LINE: begin
        if (is_lf) mode_nxt = M_IDLE;
      end
      M_BLOCK: begin
        if (held_r == H_SLASH && b == CH_STAR) begin
          held_nxt = H_NONE;
          if (depth_r != '1) depth_nxt = depth_r + DEPTH_BITS'(1);
        end else if (held_r == H_STAR && b == CH_SLASH) begin
          held_nxt = H_NONE;
          if (depth_r <= DEPTH_BITS'(1)) begin
            depth_nxt = '0;
            mode_nxt  = M_IDLE;
          end else begin
            depth_nxt = depth_r - DEPTH_BITS'(1);
          end
        end else begin
          held_nxt = (b == CH_SLASH) ? H_SLASH : (b == CH_STAR) ? H_STAR : H_NONE;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
        held_nxt = H_NONE;
        if (held_r == H_SLASH) begin
          if (b == CH_SLASH) begin
            mode_nxt = M_LINE;
          end else if (b == CH_STAR) begin
            mode_nxt  = M_BLOCK;
            depth_nxt = DEPTH_BITS'(1);
          end else begin
            mode_nxt  = M_TEXT;
            start_nxt = off_r - OFFSET_BITS'(1);
            do_text   = 1'b1;
          end
        end else begin
          do_idle = 1'b1;
        end
      end
    endcase

    if (do_text && ends_text(b)) begin
      toks[n] = '{kind: K_TEXT, tok_begin: to32(start_nxt),
                  tok_length: to32(off_r - start_nxt), line: line_r};
      n = n + CNT_BITS'(1);
      mode_nxt = M_IDLE;
      do_idle  = 1'b1;
    end

    if (do_idle && b > CH_SPACE) begin
      if (b == CH_SLASH && !in_end_of_source) begin
        held_nxt = H_SLASH;
      end else if (is_bracket(b)) begin
        toks[n] = '{kind: bracket_kind(b), tok_begin: to32(off_r),
                    tok_length: 32'd1, line: line_r};
        n = n + CNT_BITS'(1);
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        mode_nxt   = M_STR;
        single_nxt = (b == CH_SQUOTE);
        start_nxt  = off_inc;
      end else if (b == CH_COMMA || b == CH_SEMI) begin
        toks[n] = '{kind: K_TEXT, tok_begin: to32(off_r),
                    tok_length: 32'd1, line: line_r};
        n = n + CNT_BITS'(1);
      end else begin
        mode_nxt  = M_TEXT;
        start_nxt = off_r;
      end
    end

    if (in_end_of_source) begin
      if (mode_nxt == M_TEXT) begin
        toks[n] = '{kind: K_TEXT, tok_begin: to32(start_nxt),
                    tok_length: to32(off_inc - start_nxt), line: line_inc};
        n = n + CNT_BITS'(1);
        toks[n] = '{kind: K_END_OK, tok_begin: to32(off_inc),
                    tok_length: 32'd0, line: line_inc};
        n = n + CNT_BITS'(1);
      end else if (mode_nxt == M_STR || mode_nxt == M_ESC) begin
        toks[n] = '{kind: K_ERROR, tok_begin: to32(start_nxt),
                    tok_length: to32(off_inc - start_nxt), line: line_inc};
        n = n + CNT_BITS'(1);
      end else begin
        toks[n] = '{kind: K_END_OK, tok_begin: to32(off_inc),
                    tok_length: 32'd0, line: line_inc};
        n = n + CNT_BITS'(1);
      end
      mode_nxt   = M_IDLE;
      held_nxt   = H_NONE;
      off_nxt    = '0;
      line_nxt   = 32'd1;
      start_nxt  = '0;
      depth_nxt  = '0;
      single_nxt = 1'b0;
    end
  end

  assign bundle.cnt  = n;
  assign bundle.toks = toks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      held_r   <= H_NONE;
      off_r    <= '0;
      line_r   <= 32'd1;
      start_r  <= '0;
      depth_r  <= '0;
      single_r <= 1'b0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      off_r    <= off_nxt;
      line_r   <= line_nxt;
      start_r  <= start_nxt;
      depth_r  <= depth_nxt;
      single_r <= single_nxt;
    end
  end

endmodule

// ===== design/btt_queue.sv =====
// Short bundle queue between the lexer front end and the token emitter.
// Depends on btt_pkg; register based, one write and one read port.
module btt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  btt_pkg::bundle_t push_data,
  input  logic             pop,
  output btt_pkg::bundle_t head,
  output logic             not_empty,
  output logic             full
);
  import btt_pkg::*;

  bundle_t                ent_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0]  cnt_r, cnt_nxt;

  assign head      = ent_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == Q_CNT_BITS'(Q_DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_BITS'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + Q_CNT_BITS'(1);
    else if (pop && !push) cnt_nxt = cnt_r - Q_CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== design/btt_back.sv =====
// Token emitter: walks the head bundle one token per transaction.
// Depends on btt_pkg; pops the queue after the last token of a bundle.
module btt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  btt_pkg::bundle_t head,
  input  logic             head_valid,
  input  logic             out_ready,
  output logic             pop,
  output logic             out_valid,
  output logic [3:0]       out_token_kind,
  output logic [31:0]      out_token_begin,
  output logic [31:0]      out_token_length,
  output logic [31:0]      out_line_number,
  output logic             out_last_result
);
  import btt_pkg::*;

  logic [CNT_BITS-1:0] slot_r, slot_nxt;
  tok_t                cur;
  logic                fire;

  assign cur              = head.toks[slot_r];
  assign out_valid        = head_valid;
  assign out_token_kind   = cur.kind;
  assign out_token_begin  = cur.tok_begin;
  assign out_token_length = cur.tok_length;
  assign out_line_number  = cur.line;
  assign out_last_result  = (slot_r == head.cnt - CNT_BITS'(1));
  assign fire             = out_valid && out_ready;
  assign pop              = fire && out_last_result;

  always_comb begin
    slot_nxt = slot_r;
    if (pop) slot_nxt = '0;
    else if (fire) slot_nxt = slot_r + CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

// ===== design/bracket_text_tokenizer_core.sv =====
// Top level of the bracket text tokenizer: front end, bundle queue, emitter.
// Depends on btt_pkg, btt_front, btt_queue, btt_back and the macro header.
//
//   channel | ports                                   | direction
//   input   | in_valid/in_ready, in_src_byte, in_end_of_source | in
//   result  | out_valid/out_ready, out_token_*, out_line_number, out_last_result | out
//
// One source byte is taken per cycle while the two-entry bundle queue has room.
// Each byte yields zero to three tokens; the emitter sends one token per cycle
// while out_ready is high, so a byte with k tokens takes k result transactions.
// Reset (rst_n low, synchronous) returns the lexer to offset 0, line 1 and
// empties the queue. Input and output stall independently through the queue.
`include "bracket_text_tokenizer_core_macros.svh"
module bracket_text_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_src_byte,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [31:0] out_token_begin,
  output logic [31:0] out_token_length,
  output logic [31:0] out_line_number,
  output logic        out_last_result
);
  import btt_pkg::*;

  bundle_t front_bundle;
  bundle_t head;
  logic    take;
  logic    push;
  logic    pop;
  logic    head_valid;
  logic    q_full;
  logic    status_tok;

  assign in_ready   = !q_full;
  assign take       = in_valid && in_ready;
  assign push       = take && (front_bundle.cnt != '0);
  assign status_tok = (out_token_kind == K_END_OK) || (out_token_kind == K_ERROR);

  btt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .in_src_byte      (in_src_byte),
    .in_end_of_source (in_end_of_source),
    .bundle           (front_bundle)
  );

  btt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_bundle),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .full      (q_full)
  );

  btt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .head_valid       (head_valid),
    .out_ready        (out_ready),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_token_kind   (out_token_kind),
    .out_token_begin  (out_token_begin),
    .out_token_length (out_token_length),
    .out_line_number  (out_line_number),
    .out_last_result  (out_last_result)
  );

  `BTT_ASSERT(a_head_nonempty, head_valid |-> (head.cnt != '0))
  `BTT_ASSERT(a_group_continues, (out_valid && out_ready && !out_last_result) |=> out_valid)
  `BTT_ASSERT(a_status_is_last, (out_valid && status_tok) |-> out_last_result)
  `BTT_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid)

endmodule

// ===== tb/tb_bracket_text_tokenizer_core.sv =====
// Testbench for bracket_text_tokenizer_core: queue-fed driver, clocked monitor, token predictor.
// Depends on btt_pkg and the bracket_text_tokenizer_core RTL; self-checking, no files.
`timescale 1ns / 100ps
module tb_bracket_text_tokenizer_core;
  import btt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int N_ITEMS        = 150;
  localparam logic [DEPTH_BITS-1:0] DEPTH_TOP = '1;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } src_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] tbegin;
    logic [31:0] tlen;
    logic [31:0] line;
    logic        last;
  } tok_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_src_byte = 8'h00;
  logic        in_end_of_source = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_token_kind;
  logic [31:0] out_token_begin;
  logic [31:0] out_token_length;
  logic [31:0] out_line_number;
  logic        out_last_result;

  bracket_text_tokenizer_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_src_byte      (in_src_byte),
    .in_end_of_source (in_end_of_source),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_begin  (out_token_begin),
    .out_token_length (out_token_length),
    .out_line_number  (out_line_number),
    .out_last_result  (out_last_result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  src_item_t   source_bytes[$];
  logic [7:0]  src_buf[$];
  tok_rec_t    pending_tokens[$];
  tok_rec_t    byte_toks[MAX_RES];
  int          n_byte_toks;

  int unsigned n_total = 0;
  int unsigned n_sent = 0;
  int unsigned n_accepted = 0;
  int unsigned n_sources = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned stall_cycles = 0;
  logic [1:0]  phase = 2'd0;
  int unsigned send_pct[3] = '{8, 52, 0};
  int unsigned recv_pct[3] = '{52, 8, 0};
  src_item_t   drv_item;

  // lexer state of the predictor
  lex_mode_t   lx_mode;
  held_t       lx_held;
  logic [31:0] lx_offset;
  logic [31:0] lx_line;
  logic [31:0] lx_start;
  logic [DEPTH_BITS-1:0] lx_depth;
  logic        lx_single;

  function automatic logic bracket_of(input logic [7:0] b, output kind_t k);
    k = K_TEXT;
    case (b)
      CH_LPAREN: k = K_OPEN_ROUND;
      CH_LBRACK: k = K_OPEN_SQUARE;
      CH_LBRACE: k = K_OPEN_CURLY;
      CH_RPAREN: k = K_CLOSE_ROUND;
      CH_RBRACK: k = K_CLOSE_SQUARE;
      CH_RBRACE: k = K_CLOSE_CURLY;
      default:   return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    kind_t k;
    if (bracket_of(b, k)) return 1'b1;
    case (b)
      CH_DQUOTE, CH_SQUOTE, CH_SPACE, CH_TAB, CH_LF, CH_CR,
      CH_BS, CH_FF, CH_NUL, CH_COMMA, CH_SEMI: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic lx_reset();
    lx_mode   = M_IDLE;
    lx_held   = H_NONE;
    lx_offset = 32'd0;
    lx_line   = 32'd1;
    lx_start  = 32'd0;
    lx_depth  = '0;
    lx_single = 1'b0;
  endtask

  task automatic emit_tok(input kind_t k, input logic [31:0] bg, input logic [31:0] len);
    if (n_byte_toks < MAX_RES) begin
      byte_toks[CNT_BITS'(n_byte_toks)] = '{kind: k, tbegin: bg, tlen: len, line: lx_line,
                                            last: 1'b0};
      n_byte_toks++;
    end
  endtask

  task automatic lex_idle(input logic [7:0] b, input logic [31:0] off, input logic eos);
    kind_t k;
    if (b <= CH_SPACE) return;
    if (b == CH_SLASH && !eos) begin
      lx_held = H_SLASH;
    end else if (bracket_of(b, k)) begin
      emit_tok(k, off, 32'd1);
    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
      lx_mode   = M_STR;
      lx_single = (b == CH_SQUOTE);
      lx_start  = off + 32'd1;
    end else if (b == CH_COMMA || b == CH_SEMI) begin
      emit_tok(K_TEXT, off, 32'd1);
    end else begin
      lx_mode  = M_TEXT;
      lx_start = off;
    end
  endtask

  task automatic lex_text(input logic [7:0] b, input logic [31:0] off, input logic eos);
    if (is_delim(b)) begin
      emit_tok(K_TEXT, lx_start, off - lx_start);
      lx_mode = M_IDLE;
      lex_idle(b, off, eos);
    end
  endtask

  task automatic lex_byte(input logic [7:0] b, input logic eos);
    logic [31:0] off;
    off = lx_offset;
    n_byte_toks = 0;
    case (lx_mode)
      M_TEXT: lex_text(b, off, eos);
      M_STR: begin
        if (b == (lx_single ? CH_SQUOTE : CH_DQUOTE)) begin
          emit_tok(K_STRING, lx_start, off - lx_start);
          lx_mode = M_IDLE;
        end else if (b == CH_BSLASH) begin
          lx_mode = M_ESC;
        end
      end
      M_ESC: lx_mode = M_STR;
      M_LINE: begin
        if (b == CH_LF) lx_mode = M_IDLE;
      end
      M_BLOCK: begin
        if (lx_held == H_SLASH && b == CH_STAR) begin
          lx_held = H_NONE;
          if (lx_depth < DEPTH_TOP) lx_depth++;
        end else if (lx_held == H_STAR && b == CH_SLASH) begin
          lx_held = H_NONE;
          if (lx_depth <= DEPTH_BITS'(1)) begin
            lx_depth = '0;
            lx_mode  = M_IDLE;
          end else begin
            lx_depth--;
          end
        end else begin
          lx_held = (b == CH_SLASH) ? H_SLASH : (b == CH_STAR) ? H_STAR : H_NONE;
        end
      end
      default: begin
        lx_mode = M_IDLE;
        if (lx_held == H_SLASH) begin
          lx_held = H_NONE;
          if (b == CH_SLASH) begin
            lx_mode = M_LINE;
          end else if (b == CH_STAR) begin
            lx_mode  = M_BLOCK;
            lx_depth = DEPTH_BITS'(1);
          end else begin
            lx_mode  = M_TEXT;
            lx_start = off - 32'd1;
            lex_text(b, off, eos);
          end
        end else begin
          lx_held = H_NONE;
          lex_idle(b, off, eos);
        end
      end
    endcase
    if (b == CH_LF) lx_line++;
    lx_offset = off + 32'd1;
    if (eos) begin
      if (lx_mode == M_TEXT) begin
        emit_tok(K_TEXT, lx_start, lx_offset - lx_start);
        emit_tok(K_END_OK, lx_offset, 32'd0);
      end else if (lx_mode == M_STR || lx_mode == M_ESC) begin
        emit_tok(K_ERROR, lx_start, lx_offset - lx_start);
      end else begin
        emit_tok(K_END_OK, lx_offset, 32'd0);
      end
      lx_reset();
    end
    if (n_byte_toks > 0) byte_toks[CNT_BITS'(n_byte_toks - 1)].last = 1'b1;
    for (int i = 0; i < n_byte_toks; i++) pending_tokens.push_back(byte_toks[CNT_BITS'(i)]);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      n_errors++;
    end
  endtask

  // stimulus building
  task automatic add_b(input logic [7:0] b);
    src_buf.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_b(s[i]);
  endtask

  task automatic flush_src(input bit truncate);
    int unsigned keep;
    if (truncate && src_buf.size() > 1) begin
      keep = $urandom_range(1, src_buf.size() - 1);
      while (src_buf.size() > keep) void'(src_buf.pop_back());
    end
    for (int i = 0; i < src_buf.size(); i++)
      source_bytes.push_back('{b: src_buf[i], eos: (i == src_buf.size() - 1)});
    src_buf.delete();
    n_sources++;
  endtask

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 8))
      0, 1, 2, 3: return 8'($urandom_range(97, 122));
      4: return 8'($urandom_range(48, 57));
      5: return 8'($urandom_range(128, 255));
      6: return 8'($urandom_range(1, 7));
      7: return 8'($urandom_range(14, 31));
      default: begin
        case ($urandom_range(0, 3))
          0: return CH_SLASH;
          1: return CH_STAR;
          2: return CH_BSLASH;
          default: return 8'h23;
        endcase
      end
    endcase
  endfunction

  task automatic gen_fragment();
    int unsigned n;
    logic [7:0] q;
    logic [7:0] brk[6];
    logic [7:0] ws[7];
    brk = '{CH_LPAREN, CH_LBRACK, CH_LBRACE, CH_RPAREN, CH_RBRACK, CH_RBRACE};
    ws  = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_BS, CH_FF, CH_NUL};
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 5);
        repeat (n) add_b(word_byte());
      end
      1: begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        add_b(q);
        n = $urandom_range(0, 4);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin
              add_b(CH_BSLASH);
              add_b(8'($urandom_range(0, 255)));
            end
            1: add_b(CH_LF);
            2: add_b(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
            default: add_b(word_byte());
          endcase
        end
        add_b(q);
      end
      2: add_b(brk[3'($urandom_range(0, 5))]);
      3: add_b($urandom_range(0, 1) ? CH_COMMA : CH_SEMI);
      4: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) add_b(8'($urandom_range(1, 31)));
          else add_b(ws[3'($urandom_range(0, 6))]);
        end
      end
      5: begin
        add_text("//");
        n = $urandom_range(0, 3);
        repeat (n) begin
          q = 8'($urandom_range(0, 255));
          add_b(q == CH_LF ? 8'h78 : q);
        end
        add_b(CH_LF);
      end
      6: begin
        add_text("/*");
        n = $urandom_range(0, 5);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: add_text("/*");
            1: add_text("*/");
            2: add_b(CH_STAR);
            3: add_b(CH_SLASH);
            4: add_b(CH_LF);
            default: add_b(8'($urandom_range(0, 255)));
          endcase
        end
        add_text("*/");
      end
      7: begin
        n = $urandom_range(1, 3);
        repeat (n) add_b(8'($urandom_range(0, 255)));
      end
      8: begin
        add_b(CH_SLASH);
        add_b($urandom_range(0, 1) ? word_byte() : 8'($urandom_range(0, 255)));
      end
      default: add_b(CH_SPACE);
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (source_bytes.size() != 0 && $urandom_range(0, 99) >= send_pct[phase]) begin
        drv_item = source_bytes.pop_front();
        in_src_byte      <= drv_item.b;
        in_end_of_source <= drv_item.eos;
        in_valid         <= 1'b1;
        n_sent++;
        phase <= 2'((n_sent * 3) / (n_total + 1));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_pct[phase]);
  end

  // monitor
  always @(posedge clk) begin
    tok_rec_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        lex_byte(in_src_byte, in_end_of_source);
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        if (pending_tokens.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual kind %0d begin %0d",
                   $time, out_token_kind, out_token_begin);
          n_errors++;
        end else begin
          e = pending_tokens.pop_front();
          cmp_field("kind", 32'(e.kind), 32'(out_token_kind));
          cmp_field("begin", e.tbegin, out_token_begin);
          cmp_field("length", e.tlen, out_token_length);
          cmp_field("line", e.line, out_line_number);
          cmp_field("last", 32'(e.last), 32'(out_last_result));
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d tokens still expected", $time,
               pending_tokens.size());
      $display("bracket_text_tokenizer_core verification failed");
      $finish;
    end
  end

  initial begin
    lx_reset();
    // brackets, high byte text, comma and semicolon
    add_text("(");
    add_b(8'hFF);
    add_text(",;)[]{}");
    flush_src(1'b0);
    // escaped quote, newline inside a string, empty single-quoted string
    add_text("\"\\\"\n\"''");
    flush_src(1'b0);
    // nested block comment, then a slash that starts text
    add_text("/*/**/*//a");
    flush_src(1'b0);
    // line comment, then dangling escape at the end
    add_text("//x\n\"a\\");
    flush_src(1'b0);
    // unterminated string, unterminated comment, lone slash, lone NUL
    add_text("'ab");
    flush_src(1'b0);
    add_text("/*q");
    flush_src(1'b0);
    add_text("/");
    flush_src(1'b0);
    add_b(CH_NUL);
    flush_src(1'b0);

    n_total = N_ITEMS;
    while (source_bytes.size() < n_total) begin
      repeat ($urandom_range(1, 6)) gen_fragment();
      flush_src($urandom_range(0, 99) < 15);
    end
    n_total = source_bytes.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (n_accepted < n_total || pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d sources, %0d token transactions checked",
             n_accepted, n_sources, n_checked);
    if (n_errors == 0) begin
      $display("bracket_text_tokenizer_core verification clean");
    end else begin
      $display("%0d mismatches found", n_errors);
      $display("bracket_text_tokenizer_core verification failed");
    end
    $finish;
  end

endmodule
